@@ design/wpe_pkg.sv @@
package wpe_pkg;

    localparam int CH_BITS    = 8;
    localparam int NUM_CH     = 3;
    localparam int TICKS_W    = 15;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICKS_W;
    localparam int PROD_W     = CH_BITS + PCT_W;

    // x / 100 == (x * 5243) >> 19, exact for x < 43690 (x here stays below 25501)
    localparam int DIV_MUL_W  = 13;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5243;
    localparam int DIV_SHIFT  = 19;

    localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

    localparam logic [PCT_W-1:0]   RST_BRIGHT    = 7'd50;
    localparam logic [TICKS_W-1:0] RST_ZERO_HIGH = 15'd14;
    localparam logic [TICKS_W-1:0] RST_ZERO_LOW  = 15'd34;
    localparam logic [TICKS_W-1:0] RST_ONE_HIGH  = 15'd34;
    localparam logic [TICKS_W-1:0] RST_ONE_LOW   = 15'd14;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd4;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [TICKS_W-1:0] high_ticks;
        logic [TICKS_W-1:0] low_ticks;
        logic               bit_value;
        logic               last_pulse;
    } t_pulse;

    typedef struct packed {
        logic [PCT_W-1:0]   brightness;
        logic [TICKS_W-1:0] zero_high;
        logic [TICKS_W-1:0] zero_low;
        logic [TICKS_W-1:0] one_high;
        logic [TICKS_W-1:0] one_low;
    } t_cfg;

endpackage

@@ design/ws2812_pixel_pulse_encoder.sv @@
// Path: an accepted pixel beat passes the input register, the brightness multiply register
// and the shift register load before its first pulse beat is valid.
// Throughput: 24 pulse beats per pixel, one per cycle while the receiver is ready; the shift
// register reloads in the cycle its last pulse is taken, so pixels stream with no gap.
// Reset: synchronous active low; clears all valid state and restores brightness 50
// and timing 14/34 (zero bit) and 34/14 (one bit).
module ws2812_pixel_pulse_encoder
    import wpe_pkg::*;
#(
    parameter int CHANNEL_BITS = CH_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    output logic                  o_pix_ready,
    input  t_pixel                i_pixel,
    output logic                  o_pulse_valid,
    input  logic                  i_pulse_ready,
    output t_pulse                o_pulse,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                          cfg;
    logic                          word_valid;
    logic                          word_ready;
    logic [NUM_CH*CHANNEL_BITS-1:0] word;

    wpe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wpe_scale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_pix_valid),
        .o_ready      (o_pix_ready),
        .i_pixel      (i_pixel),
        .i_brightness (cfg.brightness),
        .o_valid      (word_valid),
        .i_ready      (word_ready),
        .o_word       (word)
    );

    wpe_serializer #(.CHANNEL_BITS(CHANNEL_BITS)) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (word_valid),
        .o_ready (word_ready),
        .i_word  (word),
        .i_cfg   (cfg),
        .o_valid (o_pulse_valid),
        .i_ready (i_pulse_ready),
        .o_pulse (o_pulse)
    );

endmodule

@@ design/wpe_cfg.sv @@
module wpe_cfg
    import wpe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [PCT_W-1:0] pct;

    assign pct = i_cfg_data[PCT_W-1:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRIGHT:    n_cfg.brightness = (pct > PERCENT_FULL) ? PERCENT_FULL : pct;
                REG_ZERO_HIGH: n_cfg.zero_high  = i_cfg_data[TICKS_W-1:0];
                REG_ZERO_LOW:  n_cfg.zero_low   = i_cfg_data[TICKS_W-1:0];
                REG_ONE_HIGH:  n_cfg.one_high   = i_cfg_data[TICKS_W-1:0];
                REG_ONE_LOW:   n_cfg.one_low    = i_cfg_data[TICKS_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= RST_BRIGHT;
            r_cfg.zero_high  <= RST_ZERO_HIGH;
            r_cfg.zero_low   <= RST_ZERO_LOW;
            r_cfg.one_high   <= RST_ONE_HIGH;
            r_cfg.one_low    <= RST_ONE_LOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/wpe_scale.sv @@
module wpe_scale
    import wpe_pkg::*;
#(
    parameter int CHANNEL_BITS = CH_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_pixel                    i_pixel,
    input  logic [PCT_W-1:0]          i_brightness,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [NUM_CH*CHANNEL_BITS-1:0] o_word
);

    localparam int PW = CHANNEL_BITS + PCT_W;
    localparam int QW = PW + DIV_MUL_W;

    logic         r_v1;
    t_pixel       r_pix;
    logic         r_v2;
    logic [PW-1:0] r_prod [NUM_CH];
    logic         adv1;
    logic         adv2;
    logic [CHANNEL_BITS-1:0] chan [NUM_CH];
    logic [QW-1:0]           quot [NUM_CH];

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // wire order: green, red, blue
    assign chan[0] = r_pix.green;
    assign chan[1] = r_pix.red;
    assign chan[2] = r_pix.blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_pix <= i_pixel;
        if (adv2 && r_v1) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= PW'(chan[c]) * PW'(i_brightness);
            end
        end
    end

    // divide by one hundred through the reciprocal
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            quot[c] = (QW'(r_prod[c]) * QW'(DIV_MUL)) >> DIV_SHIFT;
            o_word[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS] = quot[c][CHANNEL_BITS-1:0];
        end
    end

    assign o_valid = r_v2;

endmodule

@@ design/wpe_serializer.sv @@
module wpe_serializer
    import wpe_pkg::*;
#(
    parameter int CHANNEL_BITS = CH_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [NUM_CH*CHANNEL_BITS-1:0] i_word,
    input  t_cfg                          i_cfg,
    output logic                          o_valid,
    input  logic                          i_ready,
    output t_pulse                        o_pulse
);

    localparam int WORD_W = NUM_CH * CHANNEL_BITS;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

    logic              r_busy;
    logic [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]  r_cnt;
    logic              is_last;
    logic              take;
    logic              load;
    logic              cur_bit;

    assign is_last = (r_cnt == LAST);
    assign take    = r_busy && i_ready;
    assign o_ready = !r_busy || (i_ready && is_last);
    assign load    = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (take) begin
            if (is_last) r_busy <= 1'b0;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // shift MSB first
    always_ff @(posedge i_clk) begin
        if (load) r_word <= i_word;
        else if (take) r_word <= {r_word[WORD_W-2:0], 1'b0};
    end

    assign cur_bit = r_word[WORD_W-1];

    assign o_valid            = r_busy;
    assign o_pulse.bit_value  = cur_bit;
    assign o_pulse.last_pulse = is_last;
    assign o_pulse.high_ticks = cur_bit ? i_cfg.one_high : i_cfg.zero_high;
    assign o_pulse.low_ticks  = cur_bit ? i_cfg.one_low  : i_cfg.zero_low;

endmodule

@@ sim/ws2812_pixel_pulse_encoder_tb.sv @@
module ws2812_pixel_pulse_encoder_tb;
    import wpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_MAX      = (1 << TICKS_W) - 1;
    localparam int LEVEL_MAX     = (1 << CH_BITS) - 1;
    localparam int PCT_MAX       = (1 << PCT_W) - 1;
    localparam int MAX_GAP       = 14;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_PIXELS  = 60;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_REPORTS   = 20;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_pix_valid   = 1'b0;
    logic                  o_pix_ready;
    t_pixel                i_pixel       = '0;
    logic                  o_pulse_valid;
    logic                  i_pulse_ready = 1'b0;
    t_pulse                o_pulse;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_cfg   led_cfg = '{RST_BRIGHT, RST_ZERO_HIGH, RST_ZERO_LOW, RST_ONE_HIGH, RST_ONE_LOW};
    t_pixel pixel_queue[$];
    t_pulse expected_pulses[$];

    int pix_offered   = 0;
    int pix_accepted  = 0;
    int pix_gap       = 0;
    int pulses_taken  = 0;
    int pulses_paced  = 0;
    int ready_gap     = 0;
    int input_stalls  = 0;
    int reg_writes    = 0;
    int errors        = 0;
    int cycles        = 0;
    bit quiet_sender   = 1'b0;
    bit quiet_receiver = 1'b0;
    bit hold_off       = 1'b0;

    ws2812_pixel_pulse_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel       (i_pixel),
        .o_pulse_valid (o_pulse_valid),
        .i_pulse_ready (i_pulse_ready),
        .o_pulse       (o_pulse),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [CH_BITS-1:0] dim_level(input logic [CH_BITS-1:0] level);
        return CH_BITS'((int'(level) * int'(led_cfg.brightness)) / int'(PERCENT_FULL));
    endfunction

    // Green goes out first, then red, then blue, each MSB first.
    function automatic void encode_pixel(input t_pixel px);
        logic [CH_BITS-1:0] chan [NUM_CH];
        t_pulse p;
        chan[0] = dim_level(px.green);
        chan[1] = dim_level(px.red);
        chan[2] = dim_level(px.blue);
        for (int c = 0; c < NUM_CH; c++) begin
            for (int b = CH_BITS - 1; b >= 0; b--) begin
                p.bit_value  = chan[c][b];
                p.high_ticks = p.bit_value ? led_cfg.one_high : led_cfg.zero_high;
                p.low_ticks  = p.bit_value ? led_cfg.one_low : led_cfg.zero_low;
                p.last_pulse = (c == NUM_CH - 1) && (b == 0);
                expected_pulses.push_back(p);
            end
        end
    endfunction

    function automatic logic [CH_BITS-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CH_BITS'($urandom_range(0, LEVEL_MAX));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("pulse %0d: %s got %0d want %0d", pulses_taken, what, got, want);
        end
    endtask

    task automatic queue_px(input int r, input int g, input int b);
        pixel_queue.push_back(t_pixel'{CH_BITS'(r), CH_BITS'(g), CH_BITS'(b)});
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic [PCT_W-1:0] pct;
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pct = data[PCT_W-1:0];
        case (idx)
            REG_BRIGHT:    led_cfg.brightness = (pct > PERCENT_FULL) ? PERCENT_FULL : pct;
            REG_ZERO_HIGH: led_cfg.zero_high = data;
            REG_ZERO_LOW:  led_cfg.zero_low = data;
            REG_ONE_HIGH:  led_cfg.one_high = data;
            REG_ONE_LOW:   led_cfg.one_low = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_timing(input int zh, input int zl, input int oh, input int ol);
        set_reg(REG_ZERO_HIGH, CFG_DATA_W'(zh));
        set_reg(REG_ZERO_LOW, CFG_DATA_W'(zl));
        set_reg(REG_ONE_HIGH, CFG_DATA_W'(oh));
        set_reg(REG_ONE_LOW, CFG_DATA_W'(ol));
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        wait (pixel_queue.size() == 0 && pix_accepted == pix_offered
              && expected_pulses.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: hold each beat until taken, then idle for the drawn gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pix_valid <= 1'b0;
        end else if (pix_accepted == pix_offered) begin
            if (pix_gap > 0) begin
                pix_gap = pix_gap - 1;
                i_pix_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                i_pixel     <= pixel_queue.pop_front();
                i_pix_valid <= 1'b1;
                pix_offered = pix_offered + 1;
                pix_gap = quiet_sender ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                i_pix_valid <= 1'b0;
            end
        end
    end

    // Receiver: after each taken pulse, drop ready for the drawn gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pulse_ready <= 1'b0;
        end else begin
            if (pulses_taken != pulses_paced) begin
                pulses_paced = pulses_taken;
                ready_gap = quiet_receiver ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (ready_gap > 0) begin
                ready_gap = ready_gap - 1;
                i_pulse_ready <= 1'b0;
            end else begin
                i_pulse_ready <= !hold_off;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pulse want;
        if (i_rst_n) begin
            if (i_pix_valid && !o_pix_ready) input_stalls++;
            if (i_pix_valid && o_pix_ready) begin
                encode_pixel(i_pixel);
                pix_accepted++;
            end
            if (o_pulse_valid && i_pulse_ready) begin
                pulses_taken++;
                if (expected_pulses.size() == 0) begin
                    report_mismatch("unexpected pulse, queue depth", 0, 0);
                end else begin
                    want = expected_pulses.pop_front();
                    if (o_pulse.high_ticks !== want.high_ticks)
                        report_mismatch("high_ticks", o_pulse.high_ticks, want.high_ticks);
                    if (o_pulse.low_ticks !== want.low_ticks)
                        report_mismatch("low_ticks", o_pulse.low_ticks, want.low_ticks);
                    if (o_pulse.bit_value !== want.bit_value)
                        report_mismatch("bit_value", o_pulse.bit_value, want.bit_value);
                    if (o_pulse.last_pulse !== want.last_pulse)
                        report_mismatch("last_pulse", o_pulse.last_pulse, want.last_pulse);
                end
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and back-pressures the pixel side.
    initial begin
        wait (pix_accepted >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] data;
        int pct;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: half brightness, default timing.
        queue_px(0, 0, 0);
        queue_px(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        queue_px(1, 2, 3);
        wait_drained();

        // Full brightness with extreme timing.
        set_reg(REG_BRIGHT, CFG_DATA_W'(PERCENT_FULL));
        set_timing(1, TICK_MAX, TICK_MAX, 1);
        queue_px(LEVEL_MAX, 0, 0);
        queue_px(0, LEVEL_MAX, 0);
        queue_px(0, 0, LEVEL_MAX);
        queue_px('haa, 'h55, 'h80);
        queue_px('h01, 'h7f, 'hfe);
        wait_drained();

        // Brightness above full clamps; zero timing passes through unchanged.
        set_reg(REG_BRIGHT, CFG_DATA_W'(PCT_MAX));
        set_timing(0, TICK_MAX, 0, 0);
        queue_px(LEVEL_MAX, 'h80, 1);
        queue_px(0, 0, 0);
        wait_drained();

        // Upper data bits above the percent field are dropped; unused indexes ignored.
        set_reg(REG_BRIGHT, CFG_DATA_W'('h7f00 | (int'(PERCENT_FULL) + 1)));
        for (int k = int'(REG_ONE_LOW) + 1; k < (1 << CFG_IDX_W); k++) begin
            set_reg(CFG_IDX_W'(k), CFG_DATA_W'(TICK_MAX));
        end
        @(posedge i_clk);
        queue_px(200, 100, 50);
        wait_drained();

        set_reg(REG_BRIGHT, '0);
        @(posedge i_clk);
        queue_px(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
        wait_drained();

        set_reg(REG_BRIGHT, CFG_DATA_W'(1));
        @(posedge i_clk);
        queue_px(LEVEL_MAX, 199, 100);
        wait_drained();

        set_reg(REG_BRIGHT, CFG_DATA_W'(int'(PERCENT_FULL) - 1));
        @(posedge i_clk);
        queue_px(LEVEL_MAX, 101, 99);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: pct = PERCENT_FULL;
                1: pct = $urandom_range(int'(PERCENT_FULL) + 1, PCT_MAX);
                4: pct = 0;
                default: pct = $urandom_range(0, PERCENT_FULL);
            endcase
            data = CFG_DATA_W'($urandom_range(0, TICK_MAX));
            data[PCT_W-1:0] = PCT_W'(pct);
            set_reg(REG_BRIGHT, data);
            for (int k = int'(REG_ONE_LOW) + 1; k < (1 << CFG_IDX_W); k++) begin
                set_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, TICK_MAX)));
            end
            if (p == 2) begin
                set_timing(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
            end else if (p == 3) begin
                set_timing(1, 1, 1, 1);
            end else begin
                set_timing($urandom_range(0, TICK_MAX), $urandom_range(0, TICK_MAX),
                           $urandom_range(0, TICK_MAX), $urandom_range(0, TICK_MAX));
            end
            quiet_sender   = (p % 2 == 1);
            quiet_receiver = (p % 3 == 1);
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                pixel_queue.push_back(t_pixel'{rand_level(), rand_level(), rand_level()});
            end
            wait_drained();
        end

        while (expected_pulses.size() > 0) begin
            report_mismatch("missing pulse, still queued", 0, expected_pulses.size());
            void'(expected_pulses.pop_front());
        end

        $display("encoded %0d pixels into %0d pulses across %0d register writes",
                 pix_accepted, pulses_taken, reg_writes);
        $display("pixel side stalled %0d cycles, %0d mismatches", input_stalls, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
